// ===== design/mch_pkg.sv =====
// Package for the calibrated magnetometer heading block.
// Holds widths, register indexes, reset values, sequencer states and the CORDIC angle table.
// No dependencies; every other design file uses it.
package mch_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int CORDIC_STEPS = 16;

    localparam int SPAN_W   = SAMPLE_BITS + 1;
    localparam int DIFF_W   = SAMPLE_BITS + 3;
    localparam int ADIFF_W  = SAMPLE_BITS + 2;
    localparam int FRAC_W   = 14;
    localparam int DVD_W    = ADIFF_W + FRAC_W + 1;
    localparam int DVS_W    = SAMPLE_BITS + 1;
    localparam int REM_W    = DVS_W + 1;
    localparam int DCNT_W   = $clog2(DVD_W);
    localparam int NORM_W   = 16;
    localparam int CW       = NORM_W + 8 + 3;
    localparam int Z_W      = 27;
    localparam int STEP_W   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int MAG_W    = Z_W - 15;
    localparam int H_W      = MAG_W + 1;
    localparam int HEAD_W   = 9;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int Z180     = 180 * 65536;
    localparam int HALF_Q16 = 32768;
    localparam int NORM_MAX = 32767;
    localparam int NORM_MIN_MAG = 32768;
    localparam int DEG_FULL = 360;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = (SAMPLE_BITS)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = (SAMPLE_BITS)'(1 << (SAMPLE_BITS - 1));

    localparam logic signed [SAMPLE_BITS-1:0] RST_MIN_X = -(SAMPLE_BITS)'(474);
    localparam logic signed [SAMPLE_BITS-1:0] RST_MAX_X = (SAMPLE_BITS)'(36);
    localparam logic signed [SAMPLE_BITS-1:0] RST_MIN_Y = -(SAMPLE_BITS)'(257);
    localparam logic signed [SAMPLE_BITS-1:0] RST_MAX_Y = (SAMPLE_BITS)'(238);

    localparam logic [2:0] REG_MIN_X   = 3'd0;
    localparam logic [2:0] REG_MAX_X   = 3'd1;
    localparam logic [2:0] REG_MIN_Y   = 3'd2;
    localparam logic [2:0] REG_MAX_Y   = 3'd3;
    localparam logic [2:0] REG_USE_TRK = 3'd4;

    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_MEASURE   = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DSET = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_CSET = 6'b001000,
        ST_CORD = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = Z_W'(2949120);
            5'd1:  v = Z_W'(1740967);
            5'd2:  v = Z_W'(919879);
            5'd3:  v = Z_W'(466945);
            5'd4:  v = Z_W'(234379);
            5'd5:  v = Z_W'(117304);
            5'd6:  v = Z_W'(58666);
            5'd7:  v = Z_W'(29335);
            5'd8:  v = Z_W'(14668);
            5'd9:  v = Z_W'(7334);
            5'd10: v = Z_W'(3667);
            5'd11: v = Z_W'(1833);
            5'd12: v = Z_W'(917);
            5'd13: v = Z_W'(458);
            5'd14: v = Z_W'(229);
            5'd15: v = Z_W'(115);
            5'd16: v = Z_W'(57);
            5'd17: v = Z_W'(29);
            5'd18: v = Z_W'(14);
            5'd19: v = Z_W'(7);
            5'd20: v = Z_W'(4);
            5'd21: v = Z_W'(2);
            5'd22: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/mch_stream_if.sv =====
// Valid/ready stream interfaces for samples in and headings out.
// Depends on mch_pkg for field widths.
interface mch_sample_if;
    logic valid;
    logic ready;
    logic opcode;
    logic signed [mch_pkg::SAMPLE_BITS-1:0] mag_x;
    logic signed [mch_pkg::SAMPLE_BITS-1:0] mag_y;
    modport source (output valid, output opcode, output mag_x, output mag_y, input ready);
    modport sink (input valid, input opcode, input mag_x, input mag_y, output ready);
endinterface

interface mch_result_if;
    logic valid;
    logic ready;
    logic [mch_pkg::HEAD_W-1:0] heading_deg;
    logic fault;
    modport source (output valid, output heading_deg, output fault, input ready);
    modport sink (input valid, input heading_deg, input fault, output ready);
endinterface

// ===== design/magnetometer_calibrated_heading_core.sv =====
// Calibrated 2D compass heading core: bound tracking, normalizing divider and CORDIC.
// Depends on mch_pkg and the stream interfaces in mch_stream_if.sv.
//
// A calibrate transfer widens the tracked bounds in the cycle it is taken and frees the
// input again at once. A measure transfer runs one shared restoring divider bit-serially
// for each axis, with a setup state before its division steps, then a CORDIC setup
// state and the CORDIC steps, and the input is ready again in the same cycle as the
// measure result becomes valid. A zero span fault goes from the transfer straight to
// the final state, a zero normalized vector from the CORDIC setup. The input is not
// ready while a measure is in progress, and a stalled output holds the sequencer in its
// final state. One result register lets a new sample be taken while the previous heading
// still waits on the output.
module magnetometer_calibrated_heading_core (
    input  logic clk,
    input  logic rst_n,
    mch_sample_if.sink sample,
    mch_result_if.source result,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [mch_pkg::ADDR_W-1:0] paddr,
    input  logic [mch_pkg::DATA_W-1:0] pwdata,
    output logic [mch_pkg::DATA_W-1:0] prdata,
    output logic pready
);
    import mch_pkg::*;

    localparam int S = SAMPLE_BITS;

    logic signed [S-1:0] def_min_x_reg, def_max_x_reg, def_min_y_reg, def_max_y_reg;
    logic use_trk_reg;
    logic signed [S-1:0] trk_min_x_reg, trk_max_x_reg, trk_min_y_reg, trk_max_y_reg;

    state_t state_reg, state_next;

    logic signed [S-1:0] mx_reg, my_reg, lox_reg, hix_reg, loy_reg, hiy_reg;
    logic axis_reg;
    logic neg_reg;
    logic fault_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [REM_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic signed [NORM_W-1:0] nx_reg, ny_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0] z_reg;
    logic [STEP_W-1:0] step_reg;
    logic out_valid_reg;
    logic [HEAD_W-1:0] out_head_reg;
    logic out_fault_reg;

    logic in_fire, cfg_wr;
    logic signed [S-1:0] sel_lox, sel_hix, sel_loy, sel_hiy;
    logic zero_span;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign sample.ready = (state_reg == ST_IDLE);
    assign in_fire = sample.valid && sample.ready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[ADDR_W-1:2])
            REG_MIN_X:   prdata = DATA_W'(def_min_x_reg);
            REG_MAX_X:   prdata = DATA_W'(def_max_x_reg);
            REG_MIN_Y:   prdata = DATA_W'(def_min_y_reg);
            REG_MAX_Y:   prdata = DATA_W'(def_max_y_reg);
            REG_USE_TRK: prdata = DATA_W'(use_trk_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_min_x_reg <= RST_MIN_X;
            def_max_x_reg <= RST_MAX_X;
            def_min_y_reg <= RST_MIN_Y;
            def_max_y_reg <= RST_MAX_Y;
            use_trk_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[ADDR_W-1:2])
                REG_MIN_X:   def_min_x_reg <= pwdata[S-1:0];
                REG_MAX_X:   def_max_x_reg <= pwdata[S-1:0];
                REG_MIN_Y:   def_min_y_reg <= pwdata[S-1:0];
                REG_MAX_Y:   def_max_y_reg <= pwdata[S-1:0];
                REG_USE_TRK: use_trk_reg   <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        if (use_trk_reg)
        begin
            sel_lox = trk_min_x_reg;
            sel_hix = trk_max_x_reg;
            sel_loy = trk_min_y_reg;
            sel_hiy = trk_max_y_reg;
        end
        else
        begin
            sel_lox = def_min_x_reg;
            sel_hix = def_max_x_reg;
            sel_loy = def_min_y_reg;
            sel_hiy = def_max_y_reg;
        end
        zero_span = (sel_lox == sel_hix) || (sel_loy == sel_hiy);
    end

    // Divider setup for the current axis.
    logic signed [S-1:0] ax_v, ax_lo, ax_hi;
    logic signed [SPAN_W-1:0] span_w;
    logic signed [DIFF_W-1:0] diff_w;
    logic [ADIFF_W-1:0] adiff_w;
    logic [S-1:0] aspan_w;
    logic [DVD_W-1:0] dvd_init;

    always_comb
    begin
        ax_v  = axis_reg ? my_reg : mx_reg;
        ax_lo = axis_reg ? loy_reg : lox_reg;
        ax_hi = axis_reg ? hiy_reg : hix_reg;
        span_w = {ax_hi[S-1], ax_hi} - {ax_lo[S-1], ax_lo};
        diff_w = {{2{ax_v[S-1]}}, ax_v, 1'b0} - {{3{ax_lo[S-1]}}, ax_lo}
               - {{3{ax_hi[S-1]}}, ax_hi};
        adiff_w = diff_w[DIFF_W-1] ? ADIFF_W'(-diff_w) : diff_w[ADIFF_W-1:0];
        aspan_w = span_w[SPAN_W-1] ? S'(-span_w) : span_w[S-1:0];
        dvd_init = {adiff_w, 1'b0, {FRAC_W{1'b0}}} + DVD_W'(aspan_w);
    end

    // One restoring division step.
    logic [REM_W-1:0] trial;
    logic ge;
    logic [DVD_W-1:0] quo_fin;
    logic signed [NORM_W-1:0] norm_w;

    always_comb
    begin
        trial = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
        ge = (trial >= {1'b0, dvs_reg});
        quo_fin = {quo_reg[DVD_W-2:0], ge};
        if (!neg_reg)
            norm_w = (quo_fin > DVD_W'(NORM_MAX)) ? NORM_W'(NORM_MAX) : quo_fin[NORM_W-1:0];
        else if (quo_fin > DVD_W'(NORM_MIN_MAG))
            norm_w = NORM_W'(NORM_MIN_MAG);
        else
            norm_w = NORM_W'(-quo_fin[NORM_W-1:0]);
    end

    // CORDIC setup and step.
    logic signed [CW-1:0] cx0, cy0, xs, ys;
    logic signed [Z_W-1:0] at_w;

    always_comb
    begin
        cx0 = {{(CW-NORM_W-8){ny_reg[NORM_W-1]}}, ny_reg, 8'b0};
        cy0 = {{(CW-NORM_W-8){nx_reg[NORM_W-1]}}, nx_reg, 8'b0};
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at_w = atan_q16(5'(step_reg));
    end

    // Heading from the accumulated angle.
    logic signed [Z_W:0] s_w;
    logic [Z_W:0] rnd_w;
    logic signed [H_W-1:0] h_w, hw_w;

    always_comb
    begin
        s_w = {z_reg[Z_W-1], z_reg} - (Z_W+1)'(Z180);
        rnd_w = (s_w[Z_W] ? (Z_W+1)'(-s_w) : s_w) + (Z_W+1)'(HALF_Q16);
        h_w = s_w[Z_W] ? -{1'b0, rnd_w[Z_W:16]} : {1'b0, rnd_w[Z_W:16]};
        hw_w = h_w;
        if (h_w < 0)
            hw_w = h_w + H_W'(DEG_FULL);
        else if (h_w >= H_W'(DEG_FULL))
            hw_w = h_w - H_W'(DEG_FULL);
    end

    logic out_free;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && sample.opcode == OP_MEASURE)
                    state_next = zero_span ? ST_FIN : ST_DSET;
            end
            ST_DSET: state_next = ST_DIV;
            ST_DIV:
            begin
                if (dcnt_reg == DCNT_W'(DVD_W - 1))
                    state_next = axis_reg ? ST_CSET : ST_DSET;
            end
            ST_CSET: state_next = (nx_reg == 0 && ny_reg == 0) ? ST_FIN : ST_CORD;
            ST_CORD:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            trk_min_x_reg <= SAMPLE_MAX;
            trk_max_x_reg <= SAMPLE_MIN;
            trk_min_y_reg <= SAMPLE_MAX;
            trk_max_y_reg <= SAMPLE_MIN;
            out_valid_reg <= 1'b0;
            fault_reg     <= 1'b0;
            axis_reg      <= 1'b0;
            dcnt_reg      <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && sample.opcode == OP_CALIBRATE)
                    begin
                        if (sample.mag_x < trk_min_x_reg) trk_min_x_reg <= sample.mag_x;
                        if (sample.mag_x > trk_max_x_reg) trk_max_x_reg <= sample.mag_x;
                        if (sample.mag_y < trk_min_y_reg) trk_min_y_reg <= sample.mag_y;
                        if (sample.mag_y > trk_max_y_reg) trk_max_y_reg <= sample.mag_y;
                    end
                    fault_reg <= zero_span;
                    axis_reg  <= 1'b0;
                end
                ST_DSET:
                begin
                    dcnt_reg <= '0;
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCNT_W'(DVD_W - 1))
                        axis_reg <= 1'b1;
                end
                ST_CSET:
                begin
                    step_reg  <= '0;
                    fault_reg <= (nx_reg == 0 && ny_reg == 0);
                end
                ST_CORD:
                begin
                    step_reg <= step_reg + 1'b1;
                end
                ST_FIN: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mx_reg  <= sample.mag_x;
            my_reg  <= sample.mag_y;
            lox_reg <= sel_lox;
            hix_reg <= sel_hix;
            loy_reg <= sel_loy;
            hiy_reg <= sel_hiy;
        end
        if (state_reg == ST_DSET)
        begin
            dvd_reg <= dvd_init;
            dvs_reg <= {aspan_w, 1'b0};
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= diff_w[DIFF_W-1] != span_w[SPAN_W-1];
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= ge ? REM_W'(trial - {1'b0, dvs_reg}) : trial;
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            quo_reg <= quo_fin;
            if (dcnt_reg == DCNT_W'(DVD_W - 1))
            begin
                if (axis_reg)
                    ny_reg <= norm_w;
                else
                    nx_reg <= norm_w;
            end
        end
        if (state_reg == ST_CSET)
        begin
            if (cx0 < 0)
            begin
                x_reg <= -cx0;
                y_reg <= -cy0;
                z_reg <= (cy0 >= 0) ? Z_W'(Z180) : -Z_W'(Z180);
            end
            else
            begin
                x_reg <= cx0;
                y_reg <= cy0;
                z_reg <= '0;
            end
        end
        if (state_reg == ST_CORD)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at_w;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at_w;
            end
        end
        if (state_reg == ST_FIN && out_free)
        begin
            out_head_reg  <= fault_reg ? '0 : hw_w[HEAD_W-1:0];
            out_fault_reg <= fault_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.heading_deg = out_head_reg;
    assign result.fault       = out_fault_reg;

endmodule

// ===== design/mch_checker.sv =====
// Port-level checker for the calibrated heading core, bound to the top level.
// Depends on mch_pkg and on the top level's ports.
module mch_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [mch_pkg::HEAD_W-1:0] heading_deg,
    input logic fault,
    input logic pready
);
    import mch_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heading_deg) && $stable(fault))
        else $error("Result changed while stalled.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading_deg < HEAD_W'(DEG_FULL))
        else $error("Heading out of range.");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault |-> heading_deg == '0)
        else $error("Fault result with nonzero heading.");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped.");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("Result appeared without a busy cycle before it.");

endmodule

bind magnetometer_calibrated_heading_core mch_checker u_mch_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(sample.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .heading_deg(result.heading_deg),
    .fault(result.fault),
    .pready(pready)
);

// ===== tb/testbench.sv =====
// Testbench for the calibrated magnetometer heading core.
// Uses mch_pkg, the stream interfaces and magnetometer_calibrated_heading_core.
// A built-in heading predictor checks every result transfer under several idle patterns.
`timescale 1ns / 1ps

module testbench;
    import mch_pkg::*;

    typedef struct packed {
        logic [HEAD_W-1:0] heading_deg;
        logic              fault;
    } heading_t;

    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    mch_sample_if smp ();
    mch_result_if res ();

    magnetometer_calibrated_heading_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp),
        .result  (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    longint bound_min_x, bound_max_x, bound_min_y, bound_max_y;
    logic   track_sel;
    longint trk_min_x, trk_max_x, trk_min_y, trk_max_y;
    heading_t expected_headings[$];
    int     mismatches;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_off_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(30_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic longint norm_axis(longint v, longint lo, longint span);
        longint num;
        longint an;
        longint as_;
        longint r;
        num = (2 * (v - lo) - span) * 16384;
        an  = (num < 0) ? -num : num;
        as_ = (span < 0) ? -span : span;
        r   = (2 * an + as_) / (2 * as_);
        if ((num < 0) != (span < 0))
            r = -r;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic longint cordic_deg_q16(longint xin, longint yin);
        longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                 58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                 229, 115};
        longint x;
        longint y;
        longint z;
        longint t;
        x = xin * 256;
        y = yin * 256;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y > 0)
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_tab[i];
            end
            else
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_tab[i];
            end
            x = t;
        end
        return z;
    endfunction

    task automatic predict_heading(logic op, logic signed [SAMPLE_BITS-1:0] mx,
                                   logic signed [SAMPLE_BITS-1:0] my);
        longint vx;
        longint vy;
        longint lox, hix, loy, hiy, nx, ny, s, h;
        heading_t e;
        vx = mx;
        vy = my;
        if (op == OP_CALIBRATE)
        begin
            if (vx < trk_min_x) trk_min_x = vx;
            if (vx > trk_max_x) trk_max_x = vx;
            if (vy < trk_min_y) trk_min_y = vy;
            if (vy > trk_max_y) trk_max_y = vy;
            return;
        end
        if (track_sel)
        begin
            lox = trk_min_x; hix = trk_max_x; loy = trk_min_y; hiy = trk_max_y;
        end
        else
        begin
            lox = bound_min_x; hix = bound_max_x; loy = bound_min_y; hiy = bound_max_y;
        end
        e.heading_deg = '0;
        e.fault = 1'b1;
        if (hix != lox && hiy != loy)
        begin
            nx = norm_axis(vx, lox, hix - lox);
            ny = norm_axis(vy, loy, hiy - loy);
            if (nx != 0 || ny != 0)
            begin
                s = cordic_deg_q16(ny, nx) - 180 * 65536;
                if (s >= 0)
                    h = (s + 32768) >>> 16;
                else
                    h = -(((-s) + 32768) >>> 16);
                if (h < 0) h += 360;
                if (h >= 360) h -= 360;
                if (h < 0) h = 0;
                e.heading_deg = h[HEAD_W-1:0];
                e.fault = 1'b0;
            end
        end
        expected_headings.push_back(e);
    endtask

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            res.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        heading_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_headings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: heading %0d fault %0d",
                             res.heading_deg, res.fault);
            end
            else
            begin
                e = expected_headings.pop_front();
                if (res.heading_deg !== e.heading_deg || res.fault !== e.fault)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected heading %0d fault %0d, got %0d fault %0d",
                                 e.heading_deg, e.fault, res.heading_deg, res.fault);
                end
            end
        end
    end

    task automatic send_sample(logic op, logic signed [SAMPLE_BITS-1:0] mx,
                               logic signed [SAMPLE_BITS-1:0] my);
        while ($urandom_range(99) < send_idle_pct)
        begin
            smp.valid <= 1'b0;
            @(negedge clk);
        end
        smp.valid  <= 1'b1;
        smp.opcode <= op;
        smp.mag_x  <= mx;
        smp.mag_y  <= my;
        do
            @(posedge clk);
        while (!smp.ready);
        predict_heading(op, mx, my);
        @(negedge clk);
    endtask

    task automatic drain;
        smp.valid <= 1'b0;
        while (expected_headings.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic signed [SAMPLE_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= DATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MIN_X:   bound_min_x = val;
            REG_MAX_X:   bound_max_x = val;
            REG_MIN_Y:   bound_min_y = val;
            REG_MAX_Y:   bound_max_y = val;
            REG_USE_TRK: track_sel = val[0];
            default: ;
        endcase
    endtask

    task automatic set_bounds(int lx, int hx, int ly, int hy, bit trk);
        drain();
        reg_write(REG_MIN_X, SAMPLE_BITS'(lx));
        reg_write(REG_MAX_X, SAMPLE_BITS'(hx));
        reg_write(REG_MIN_Y, SAMPLE_BITS'(ly));
        reg_write(REG_MAX_Y, SAMPLE_BITS'(hy));
        reg_write(REG_USE_TRK, SAMPLE_BITS'(trk));
    endtask

    task automatic random_bounds;
        int lx, ly, hx, hy;
        lx = $urandom_range(3000) - 2048;
        ly = $urandom_range(3000) - 2048;
        hx = lx + $urandom_range(1000, 1);
        hy = ly + $urandom_range(1000, 1);
        if (hx > 2047) hx = 2047;
        if (hy > 2047) hy = 2047;
        case ($urandom_range(9))
            0: hx = lx;
            1: hy = $urandom_range(4095) - 2048;
            2: begin lx = -2048; hx = 2047; ly = -2048; hy = 2047; end
            default: ;
        endcase
        set_bounds(lx, hx, ly, hy, $urandom_range(2) == 0);
    endtask

    task automatic test_directed;
        send_sample(OP_MEASURE, 12'sd0, 12'sd0);
        send_sample(OP_MEASURE, -12'sd2048, -12'sd2048);
        send_sample(OP_MEASURE, 12'sd2047, 12'sd2047);
        send_sample(OP_MEASURE, -12'sd2048, 12'sd2047);
        send_sample(OP_MEASURE, 12'sd2047, -12'sd2048);
        send_sample(OP_MEASURE, -12'sd219, 12'sd100);
        set_bounds(-100, 100, -200, 200, 1'b0);
        send_sample(OP_MEASURE, 12'sd0, 12'sd0);
        send_sample(OP_MEASURE, 12'sd100, 12'sd0);
        send_sample(OP_MEASURE, 12'sd0, -12'sd200);
        send_sample(OP_MEASURE, -12'sd100, 12'sd0);
        set_bounds(50, 50, -200, 200, 1'b0);
        send_sample(OP_MEASURE, 12'sd10, 12'sd10);
        set_bounds(-2048, 2047, 300, 300, 1'b0);
        send_sample(OP_MEASURE, 12'sd10, 12'sd10);
        set_bounds(100, -100, 200, -200, 1'b0);
        send_sample(OP_MEASURE, 12'sd30, -12'sd70);
        set_bounds(-2048, 2047, -2048, 2047, 1'b1);
        send_sample(OP_MEASURE, 12'sd5, -12'sd5);
        send_sample(OP_CALIBRATE, -12'sd300, 12'sd400);
        send_sample(OP_MEASURE, 12'sd5, -12'sd5);
        send_sample(OP_CALIBRATE, 12'sd250, -12'sd100);
        send_sample(OP_MEASURE, -12'sd25, 12'sd150);
        send_sample(OP_MEASURE, -12'sd2048, 12'sd2047);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        int sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(39) == 0)
                random_bounds();
            send_sample($urandom_range(2) != 0 ? OP_MEASURE : OP_CALIBRATE,
                        SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
            sent++;
        end
        drain();
    endtask

    task automatic test_pressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 500;
        repeat (5) send_sample(OP_MEASURE, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
        drain();
        repeat (3) send_sample(OP_MEASURE, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        smp.valid = 1'b0;
        smp.opcode = OP_CALIBRATE;
        smp.mag_x = '0;
        smp.mag_y = '0;
        res.ready = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        bound_min_x = -474;
        bound_max_x = 36;
        bound_min_y = -257;
        bound_max_y = 238;
        track_sel = 1'b0;
        trk_min_x = 2047;
        trk_max_x = -2048;
        trk_min_y = 2047;
        trk_max_y = -2048;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        drain();
        test_pressure();
        test_random_phase(0, 0, 150);
        test_random_phase(47, 0, 150);
        test_random_phase(0, 47, 150);
        test_random_phase(38, 38, 150);
        drain();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
